// ===== rtl/core/jac_pkg.sv =====
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

  // Filter and send policy constants.
  localparam int unsigned EMA_SHIFT  = 3;
  localparam int unsigned CHANGE_MIN = 4;

  // 14-bit output scale.
  localparam logic [13:0] V14_MAX  = 14'd16383;
  localparam logic [13:0] V14_MID  = 14'd8192;
  localparam logic [13:0] K_X_HI   = 14'd8191;
  localparam logic [13:0] K_X_LO   = 14'd8192;
  localparam logic [13:0] K_Y      = 14'd16383;

  // Divider: every quotient is below 2^14, so 14 steps are enough.
  localparam int unsigned DIV_STEPS = 14;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port address width (8 registers at 4-byte spacing).
  localparam int unsigned CFG_AW = 5;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_X_MIN      = 3'd0,
    REG_X_MAX      = 3'd1,
    REG_X_CENTER   = 3'd2,
    REG_Y_MIN      = 3'd3,
    REG_Y_MAX      = 3'd4,
    REG_RATE_LIMIT = 3'd5,
    REG_LINK_STYLE = 3'd6,
    REG_DEADZONE   = 3'd7
  } jac_reg_t;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] x_max;
    logic [15:0] x_center;
    logic [15:0] y_min;
    logic [15:0] y_max;
    logic [7:0]  rate_limit_ms;
    logic        link_style;
    logic [13:0] deadzone;
  } jac_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_DIV,
    ST_FIN,
    ST_DECIDE,
    ST_PUSH_X,
    ST_PUSH_Y
  } jac_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic map;
    logic div_step;
    logic fin;
    logic decide;
    logic push_x;
    logic push_y;
    logic axis;
  } jac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clamp;
    logic snd_x;
    logic snd_y;
    logic q_space;
  } jac_sts_t;

  // One result beat.
  typedef struct packed {
    logic        axis;
    logic [13:0] value14;
    logic        last;
  } jac_res_t;

endpackage

// ===== rtl/core/jac_in_if.sv =====
// ----------------------------------------------------------------------------
// jac_in_if
// Input channel: one beat per 1 ms tick with raw samples and time.
// ----------------------------------------------------------------------------
interface jac_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_x;
  logic [15:0] raw_y;
  logic        link_on;
  logic [31:0] now_ms;

  modport source (output valid, output raw_x, output raw_y, output link_on,
                  output now_ms, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input link_on,
                  input now_ms, output ready);
endinterface

// ===== rtl/core/jac_out_if.sv =====
// ----------------------------------------------------------------------------
// jac_out_if
// Result channel: one beat per axis position that is sent.
// ----------------------------------------------------------------------------
interface jac_out_if;
  logic        valid;
  logic        ready;
  logic        axis;
  logic [13:0] value14;
  logic        last;

  modport source (output valid, output axis, output value14, output last,
                  input ready);
  modport sink   (input valid, input axis, input value14, input last,
                  output ready);
endinterface

// ===== rtl/core/jac_regs.sv =====
// ----------------------------------------------------------------------------
// jac_regs
// APB-style configuration register file with calibration reset values.
// ----------------------------------------------------------------------------
module jac_regs
  import jac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output jac_cfg_t          cfg
);

  jac_cfg_t cfg_r;
  jac_reg_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = jac_reg_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes; the access phase completes the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_min         <= 16'd2000;
      cfg_r.x_max         <= 16'd63000;
      cfg_r.x_center      <= 16'd32500;
      cfg_r.y_min         <= 16'd2000;
      cfg_r.y_max         <= 16'd63000;
      cfg_r.rate_limit_ms <= 8'd5;
      cfg_r.link_style    <= 1'b0;
      cfg_r.deadzone      <= 14'd96;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_MIN:      cfg_r.x_min         <= pwdata[15:0];
        REG_X_MAX:      cfg_r.x_max         <= pwdata[15:0];
        REG_X_CENTER:   cfg_r.x_center      <= pwdata[15:0];
        REG_Y_MIN:      cfg_r.y_min         <= pwdata[15:0];
        REG_Y_MAX:      cfg_r.y_max         <= pwdata[15:0];
        REG_RATE_LIMIT: cfg_r.rate_limit_ms <= pwdata[7:0];
        REG_LINK_STYLE: cfg_r.link_style    <= pwdata[0];
        REG_DEADZONE:   cfg_r.deadzone      <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_X_MIN:      prdata = {16'd0, cfg_r.x_min};
      REG_X_MAX:      prdata = {16'd0, cfg_r.x_max};
      REG_X_CENTER:   prdata = {16'd0, cfg_r.x_center};
      REG_Y_MIN:      prdata = {16'd0, cfg_r.y_min};
      REG_Y_MAX:      prdata = {16'd0, cfg_r.y_max};
      REG_RATE_LIMIT: prdata = {24'd0, cfg_r.rate_limit_ms};
      REG_LINK_STYLE: prdata = {31'd0, cfg_r.link_style};
      REG_DEADZONE:   prdata = {18'd0, cfg_r.deadzone};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/jac_ctrl.sv =====
// ----------------------------------------------------------------------------
// jac_ctrl
// Sequencer: filter, map X, map Y, send decision and result pushes per tick.
// ----------------------------------------------------------------------------
module jac_ctrl
  import jac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  jac_sts_t sts,
  output jac_cmd_t cmd
);

  jac_state_t           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 axis_r, axis_nxt;

  // State, step counter and axis select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          axis_nxt  = 1'b0;
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.clamp ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_MAP;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_PUSH_X;
      end
      ST_PUSH_X: begin
        if (!sts.snd_x) begin
          state_nxt = ST_PUSH_Y;
        end else if (sts.q_space) begin
          cmd.push_x = 1'b1;
          state_nxt  = ST_PUSH_Y;
        end
      end
      ST_PUSH_Y: begin
        if (!sts.snd_y) begin
          state_nxt = ST_IDLE;
        end else if (sts.q_space) begin
          cmd.push_y = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/jac_dp.sv =====
// ----------------------------------------------------------------------------
// jac_dp
// Datapath: filters, range mapping with a shared 14-step divider, send
// decision and a two-entry result queue.
// ----------------------------------------------------------------------------
module jac_dp
  import jac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  jac_cfg_t    cfg,
  input  jac_cmd_t    cmd,
  output jac_sts_t    sts,
  input  logic [15:0] raw_x,
  input  logic [15:0] raw_y,
  input  logic        link_on,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output jac_res_t    out_res
);

  // Tick state.
  logic [15:0] filt_x_r, filt_y_r;
  logic [13:0] sent_x_r, sent_y_r;
  logic [31:0] sent_time_x_r, sent_time_y_r;
  logic        link_r;
  logic [31:0] now_r;
  logic [13:0] x14_r, y14_r;
  logic        snd_x_r, snd_y_r;

  // Divider state.
  logic [15:0] rem_r, den_r;
  logic [13:0] num_lo_r, quo_r;
  logic        clamp_r;
  logic        hi_r;

  // Result queue.
  jac_res_t    q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  q_cnt_r;

  // Exponential average, rounding toward minus infinity on the way down.
  function automatic logic [15:0] ema(input logic [15:0] filt, input logic [15:0] raw);
    logic [15:0] d;
    logic [16:0] up;
    d   = (raw >= filt) ? (raw - filt) : (filt - raw);
    up  = {1'b0, d} + 17'((1 << EMA_SHIFT) - 1);
    if (raw >= filt) begin
      ema = filt + (d >> EMA_SHIFT);
    end else begin
      ema = filt - 16'(up >> EMA_SHIFT);
    end
  endfunction

  // Send test for one axis.
  function automatic logic want_send(input logic [13:0] v, input logic [13:0] sent,
                                     input logic [31:0] t_sent, input logic [31:0] now,
                                     input logic [7:0] rate);
    logic [13:0] d;
    logic        hit;
    logic [31:0] el;
    d   = (v > sent) ? (v - sent) : (sent - v);
    hit = ((v == 14'd0) || (v == V14_MAX) || (v == V14_MID)) && (v != sent);
    el  = now - t_sent;
    want_send = ((d >= 14'(CHANGE_MIN)) || hit) && (el >= {24'd0, rate});
  endfunction

  // Range setup for the selected axis: clamp or numerator and divisor.
  logic [15:0] v, diff, den;
  logic [13:0] kmul, clamp_val;
  logic        clamp;
  logic        hi;
  logic [29:0] prod;

  always_comb begin
    v         = cmd.axis ? filt_y_r : filt_x_r;
    diff      = '0;
    den       = 16'd1;
    kmul      = '0;
    clamp     = 1'b0;
    clamp_val = '0;
    hi        = 1'b0;
    if (!cmd.axis) begin
      priority if (v <= cfg.x_min) begin
        clamp = 1'b1;
      end else if (v >= cfg.x_max) begin
        clamp     = 1'b1;
        clamp_val = V14_MAX;
      end else if (v >= cfg.x_center) begin
        diff = v - cfg.x_center;
        kmul = K_X_HI;
        den  = cfg.x_max - cfg.x_center;
        hi   = 1'b1;
      end else begin
        diff = v - cfg.x_min;
        kmul = K_X_LO;
        den  = cfg.x_center - cfg.x_min;
      end
    end else begin
      priority if (v <= cfg.y_min) begin
        clamp = 1'b1;
      end else if (v >= cfg.y_max) begin
        clamp     = 1'b1;
        clamp_val = V14_MAX;
      end else begin
        diff = v - cfg.y_min;
        kmul = K_Y;
        den  = cfg.y_max - cfg.y_min;
      end
    end
  end

  assign prod = {14'd0, diff} * {16'd0, kmul};

  // One restoring division step.
  logic [16:0] trial;
  logic        ge;
  assign trial = {rem_r, num_lo_r[13]};
  assign ge    = trial >= {1'b0, den_r};

  // The upper half of X starts at the center code.
  logic [13:0] x_map;
  assign x_map = hi_r ? (V14_MID + quo_r) : quo_r;

  // Deadzone snap on X, compared signed.
  logic signed [15:0] dz_lo, dz_hi, o_s;
  logic               in_dz;
  assign dz_lo = $signed({2'b00, V14_MID}) - $signed({2'b00, cfg.deadzone});
  assign dz_hi = $signed({2'b00, V14_MID}) + $signed({2'b00, cfg.deadzone});
  assign o_s   = $signed({2'b00, x_map});
  assign in_dz = (o_s > dz_lo) && (o_s < dz_hi);

  logic wx, wy;
  assign wx = want_send(x14_r, sent_x_r, sent_time_x_r, now_r, cfg.rate_limit_ms);
  assign wy = want_send(y14_r, sent_y_r, sent_time_y_r, now_r, cfg.rate_limit_ms);

  // Persistent per-axis state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_x_r      <= '0;
      filt_y_r      <= '0;
      sent_x_r      <= '0;
      sent_y_r      <= '0;
      sent_time_x_r <= '0;
      sent_time_y_r <= '0;
      snd_x_r       <= 1'b0;
      snd_y_r       <= 1'b0;
    end else begin
      if (cmd.load) begin
        filt_x_r <= ema(filt_x_r, raw_x);
        filt_y_r <= ema(filt_y_r, raw_y);
      end
      if (cmd.decide) begin
        snd_x_r <= wx;
        snd_y_r <= wy;
        if (wx) begin
          sent_x_r      <= x14_r;
          sent_time_x_r <= now_r;
        end
        if (wy) begin
          sent_y_r      <= y14_r;
          sent_time_y_r <= now_r;
        end
      end
    end
  end

  // Tick payload, mapping and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      link_r <= link_on;
      now_r  <= now_ms;
    end
    if (cmd.map) begin
      clamp_r  <= clamp;
      hi_r     <= hi;
      quo_r    <= clamp_val;
      rem_r    <= prod[29:14];
      num_lo_r <= prod[13:0];
      den_r    <= den;
    end
    if (cmd.div_step) begin
      rem_r    <= ge ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      quo_r    <= {quo_r[12:0], ge};
      num_lo_r <= {num_lo_r[12:0], 1'b0};
    end
    if (cmd.fin) begin
      if (!cmd.axis) begin
        x14_r <= (!clamp_r && in_dz) ? V14_MID : x_map;
      end else begin
        y14_r <= quo_r;
        if (link_r) begin
          x14_r <= cfg.link_style ? (V14_MAX - quo_r) : quo_r;
        end
      end
    end
  end

  // Two-entry result queue.
  logic     push, pop;
  jac_res_t wr_res;
  assign push = cmd.push_x || cmd.push_y;
  assign pop  = out_valid && out_ready;

  always_comb begin
    wr_res.axis    = cmd.push_y;
    wr_res.value14 = cmd.push_y ? y14_r : x14_r;
    wr_res.last    = cmd.push_y || !snd_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= wr_res;
  end

  assign out_valid = q_cnt_r != 2'd0;
  assign out_res   = q_r[rd_ptr_r];

  assign sts.clamp   = clamp;
  assign sts.snd_x   = snd_x_r;
  assign sts.snd_y   = snd_y_r;
  assign sts.q_space = q_cnt_r != 2'd2;

endmodule

// ===== rtl/core/joystick_axis_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_top
// Joystick axis conditioner: filtered, calibrated 14-bit X and Y positions.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per 1 ms tick (raw_x, raw_y, link_on, now_ms).
//   out_ch carries 0, 1 or 2 beats per tick: X before Y, last set on the
//   final beat of the tick. Calibration is written over the cfg_ APB port
//   while the block is idle; pready is always high.
//   A tick occupies the sequencer from its acceptance until its results
//   are queued: per axis it maps, runs the shared restoring divider when
//   the filtered value lies inside its calibrated range, and finishes;
//   then it decides what to send and pushes X, then Y.
//   Each pushed beat is registered in the queue, and a push waits while
//   the queue is full.
//   Results go into a two-beat queue, so a stalled receiver does not block
//   the next tick until a new result finds the queue full; the sequencer
//   then waits in place and nothing is dropped.
//   Reset (synchronous, active low) restores the calibration defaults,
//   clears the filters, last sent values and times, and empties the queue.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner_top
  import jac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  jac_in_if.sink            in_ch,
  jac_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  jac_cfg_t cfg;
  jac_cmd_t cmd;
  jac_sts_t sts;
  jac_res_t out_res;

  // Configuration registers.
  jac_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Sequencer.
  jac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  jac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .raw_x     (in_ch.raw_x),
    .raw_y     (in_ch.raw_y),
    .link_on   (in_ch.link_on),
    .now_ms    (in_ch.now_ms),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.axis    = out_res.axis;
  assign out_ch.value14 = out_res.value14;
  assign out_ch.last    = out_res.last;

  // A tick occupies the sequencer, so no beat is taken right after another.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a tick is in progress");

  // Only an X beat can be followed by another beat of the same tick.
  a_not_last_is_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.last) |-> (out_ch.axis == 1'b0))
    else $error("non-final result beat is not the X axis");

  // Y is always the final beat of its tick.
  a_y_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.axis) |-> out_ch.last)
    else $error("Y result beat without last");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the joystick axis conditioner. A bit-exact
// predictor of the filter, calibration map, link and send policy runs next
// to the block. Directed ticks come first, then random joystick motion under
// several calibrations, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import jac_pkg::*;

  // One input tick as driven on the input channel.
  typedef struct packed {
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic        link_on;
    logic [31:0] now_ms;
  } tick_t;

  // One row of the directed table. n_typed < 0 means the predictor decides.
  typedef struct {
    tick_t    tk;
    int       n_typed;
    jac_res_t beat0;
    jac_res_t beat1;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  jac_in_if  in_ch ();
  jac_out_if out_ch ();

  joystick_axis_conditioner_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow calibration and predictor state.
  jac_cfg_t    cal;
  logic [15:0] avg_x, avg_y;
  logic [13:0] sent_pos_x, sent_pos_y;
  logic [31:0] sent_ms_x, sent_ms_y;
  logic [31:0] tick_ms;

  jac_res_t    pending_positions[$];
  dir_row_t    dir_rows[$];
  int          in_idle_pct;
  int          out_idle_pct;
  int          mismatches;
  int          ticks_sent;
  int          beats_checked;

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 50)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Exponential average step: round down on the way up, up on the way down.
  function automatic logic [15:0] ema_next(logic [15:0] avg, logic [15:0] raw);
    int unsigned a, r, d;
    a = avg;
    r = raw;
    if (r >= a) begin
      a = a + ((r - a) >> EMA_SHIFT);
    end else begin
      d = r;
      d = a - d;
      a = a - ((d + (1 << EMA_SHIFT) - 1) >> EMA_SHIFT);
    end
    return 16'(a);
  endfunction

  // X map: each half scaled on its own, then snapped inside the deadzone.
  function automatic logic [13:0] pos_x(logic [15:0] v);
    int unsigned lo, hi, mid, val, pos;
    int          dz;
    lo  = cal.x_min;
    hi  = cal.x_max;
    mid = cal.x_center;
    val = v;
    if (val <= lo) return '0;
    if (val >= hi) return V14_MAX;
    if (val >= mid) pos = V14_MID + (val - mid) * K_X_HI / (hi - mid);
    else pos = (val - lo) * K_X_LO / (mid - lo);
    dz = int'(cal.deadzone);
    if (int'(pos) > int'(V14_MID) - dz && int'(pos) < int'(V14_MID) + dz) pos = V14_MID;
    return 14'(pos);
  endfunction

  // Y map: linear over the calibrated range.
  function automatic logic [13:0] pos_y(logic [15:0] v);
    int unsigned lo, hi, val;
    lo  = cal.y_min;
    hi  = cal.y_max;
    val = v;
    if (val <= lo) return '0;
    if (val >= hi) return V14_MAX;
    return 14'((val - lo) * K_Y / (hi - lo));
  endfunction

  // Send when moved enough or newly on a landmark, and the rate limit allows.
  function automatic bit send_due(logic [13:0] v, logic [13:0] prev,
                                  logic [31:0] t_prev, logic [31:0] now);
    logic [13:0] d;
    logic [31:0] elapsed;
    bit          landmark;
    d        = (v > prev) ? v - prev : prev - v;
    landmark = (v == 14'd0 || v == V14_MAX || v == V14_MID) && v != prev;
    elapsed  = now - t_prev;
    return (d >= CHANGE_MIN || landmark) && elapsed >= 32'(cal.rate_limit_ms);
  endfunction

  // Advance the predictor by one tick and return the positions it sends.
  function automatic int condition_tick(tick_t t, output jac_res_t beat0,
                                        output jac_res_t beat1);
    jac_res_t    bb[2];
    logic [13:0] x14, y14;
    int          n;
    bb[0] = '0;
    bb[1] = '0;
    n     = 0;
    avg_x = ema_next(avg_x, t.raw_x);
    avg_y = ema_next(avg_y, t.raw_y);
    x14   = pos_x(avg_x);
    y14   = pos_y(avg_y);
    if (t.link_on) x14 = cal.link_style ? (V14_MAX - y14) : y14;
    if (send_due(x14, sent_pos_x, sent_ms_x, t.now_ms)) begin
      sent_pos_x = x14;
      sent_ms_x  = t.now_ms;
      bb[n]      = '{axis: 1'b0, value14: x14, last: 1'b0};
      n++;
    end
    if (send_due(y14, sent_pos_y, sent_ms_y, t.now_ms)) begin
      sent_pos_y = y14;
      sent_ms_y  = t.now_ms;
      bb[n]      = '{axis: 1'b1, value14: y14, last: 1'b0};
      n++;
    end
    if (n > 0) bb[n-1].last = 1'b1;
    beat0 = bb[0];
    beat1 = bb[1];
    return n;
  endfunction

  // Drive one tick, with random idle cycles first, and record what it sends.
  task automatic send_tick(input tick_t t, input int n_typed,
                           input jac_res_t typed0, input jac_res_t typed1);
    jac_res_t p0, p1;
    int       n;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.raw_x   <= 16'($urandom);
      in_ch.raw_y   <= 16'($urandom);
      in_ch.link_on <= 1'($urandom);
      in_ch.now_ms  <= $urandom;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.raw_x   <= t.raw_x;
    in_ch.raw_y   <= t.raw_y;
    in_ch.link_on <= t.link_on;
    in_ch.now_ms  <= t.now_ms;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    n = condition_tick(t, p0, p1);
    if (n_typed >= 0) begin
      n  = n_typed;
      p0 = typed0;
      p1 = typed1;
    end
    if (n > 0) pending_positions.push_back(p0);
    if (n > 1) pending_positions.push_back(p1);
    ticks_sent++;
    @(negedge clk);
  endtask

  // One APB transfer: setup phase, access phase, then psel low before the task returns.
  task automatic cfg_access(input jac_reg_t r, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input jac_reg_t r, input logic [31:0] v);
    logic [31:0] unused;
    cfg_access(r, 1'b1, v, unused);
    case (r)
      REG_X_MIN:      cal.x_min         = v[15:0];
      REG_X_MAX:      cal.x_max         = v[15:0];
      REG_X_CENTER:   cal.x_center      = v[15:0];
      REG_Y_MIN:      cal.y_min         = v[15:0];
      REG_Y_MAX:      cal.y_max         = v[15:0];
      REG_RATE_LIMIT: cal.rate_limit_ms = v[7:0];
      REG_LINK_STYLE: cal.link_style    = v[0];
      REG_DEADZONE:   cal.deadzone      = v[13:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] reg_value(jac_reg_t r);
    case (r)
      REG_X_MIN:      return 32'(cal.x_min);
      REG_X_MAX:      return 32'(cal.x_max);
      REG_X_CENTER:   return 32'(cal.x_center);
      REG_Y_MIN:      return 32'(cal.y_min);
      REG_Y_MAX:      return 32'(cal.y_max);
      REG_RATE_LIMIT: return 32'(cal.rate_limit_ms);
      REG_LINK_STYLE: return 32'(cal.link_style);
      REG_DEADZONE:   return 32'(cal.deadzone);
      default:        return '0;
    endcase
  endfunction

  // Read every register back and compare with the shadow copy.
  task automatic check_regs();
    jac_reg_t    r;
    logic [31:0] got;
    for (int i = 0; i < 8; i++) begin
      r = jac_reg_t'(i);
      cfg_access(r, 1'b0, '0, got);
      if (got !== reg_value(r))
        report_mismatch($sformatf("readback of %s", r.name()), got, reg_value(r));
    end
  endtask

  // Write a full calibration; unused upper data bits carry junk.
  task automatic apply_cal(input jac_cfg_t c);
    write_reg(REG_X_MIN,      {16'($urandom), c.x_min});
    write_reg(REG_X_MAX,      {16'($urandom), c.x_max});
    write_reg(REG_X_CENTER,   {16'($urandom), c.x_center});
    write_reg(REG_Y_MIN,      {16'($urandom), c.y_min});
    write_reg(REG_Y_MAX,      {16'($urandom), c.y_max});
    write_reg(REG_RATE_LIMIT, {24'($urandom), c.rate_limit_ms});
    write_reg(REG_LINK_STYLE, {31'($urandom), c.link_style});
    write_reg(REG_DEADZONE,   {18'($urandom), c.deadzone});
    check_regs();
  endtask

  // Wait until every sent position has arrived and the block has gone idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic void add_row(input logic [15:0] rx, input logic [15:0] ry,
                                  input logic lk, input logic [31:0] ms, input int n_typed,
                                  input jac_res_t b0, input jac_res_t b1);
    dir_row_t row;
    row.tk      = '{raw_x: rx, raw_y: ry, link_on: lk, now_ms: ms};
    row.n_typed = n_typed;
    row.beat0   = b0;
    row.beat1   = b1;
    dir_rows.push_back(row);
  endfunction

  // Hold point for a stretch of motion: rails, calibration points or anywhere.
  function automatic int pick_goal(input int lo, input int mid, input int hi);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2:       return lo;
      3:       return hi;
      4:       return mid;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Sample near the goal with converter noise; now and then a wild sample.
  function automatic logic [15:0] near(input int goal);
    int v;
    if ($urandom_range(0, 99) < 4) return 16'($urandom);
    v = goal + $urandom_range(0, 40) - 20;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // Random joystick motion: the stick is held at a goal for a while, then moves.
  task automatic run_random(input int n);
    tick_t t;
    int    hold_x, hold_y, goal_x, goal_y, k;
    bit    link;
    hold_x = 0;
    hold_y = 0;
    goal_x = 0;
    goal_y = 0;
    link   = 1'b0;
    repeat (n) begin
      if (hold_x == 0) begin
        goal_x = pick_goal(cal.x_min, cal.x_center, cal.x_max);
        hold_x = $urandom_range(4, 50);
      end
      if (hold_y == 0) begin
        goal_y = pick_goal(cal.y_min, (int'(cal.y_min) + int'(cal.y_max)) / 2, cal.y_max);
        hold_y = $urandom_range(4, 50);
      end
      hold_x--;
      hold_y--;
      if ($urandom_range(0, 99) < 3) link = !link;
      // Time mostly advances one ms; sometimes it repeats, jumps or is garbage.
      k = $urandom_range(0, 99);
      if (k < 2) tick_ms = $urandom;
      else if (k < 4) tick_ms = tick_ms;
      else if (k < 12) tick_ms = tick_ms + $urandom_range(2, 600);
      else tick_ms = tick_ms + 1;
      t = '{raw_x: near(goal_x), raw_y: near(goal_y), link_on: link, now_ms: tick_ms};
      send_tick(t, -1, '0, '0);
    end
  endtask

  // Receiver stalls.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest predicted position.
  always @(posedge clk) begin : beat_check
    jac_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("beat with nothing pending, value14", out_ch.value14, 0);
      end else begin
        want = pending_positions.pop_front();
        if (out_ch.axis !== want.axis) report_mismatch("axis", out_ch.axis, want.axis);
        if (out_ch.value14 !== want.value14)
          report_mismatch("value14", out_ch.value14, want.value14);
        if (out_ch.last !== want.last) report_mismatch("last", out_ch.last, want.last);
      end
      beats_checked++;
    end
  end

  // Main sequence.
  initial begin
    jac_cfg_t c;
    jac_res_t x_top, y_top;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.raw_x   = '0;
    in_ch.raw_y   = '0;
    in_ch.link_on = 1'b0;
    in_ch.now_ms  = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    mismatches    = 0;
    ticks_sent    = 0;
    beats_checked = 0;
    in_idle_pct   = 15;
    out_idle_pct  = 56;
    cal = '{x_min: 16'd2000, x_max: 16'd63000, x_center: 16'd32500, y_min: 16'd2000,
            y_max: 16'd63000, rate_limit_ms: 8'd5, link_style: 1'b0, deadzone: 14'd96};
    avg_x      = '0;
    avg_y      = '0;
    sent_pos_x = '0;
    sent_pos_y = '0;
    sent_ms_x  = '0;
    sent_ms_y  = '0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values of the calibration.
    check_regs();

    // Narrow calibration so the directed rows reach both rails quickly.
    c = '{x_min: 16'd100, x_max: 16'd12000, x_center: 16'd6000, y_min: 16'd100,
          y_max: 16'd12000, rate_limit_ms: 8'd2, link_style: 1'b0, deadzone: 14'd50};
    apply_cal(c);

    // Directed table: still stick, rate-limited jump to full scale, full-scale
    // send, no repeat, descent through the range, link, time wrap.
    x_top = '{axis: 1'b0, value14: V14_MAX, last: 1'b0};
    y_top = '{axis: 1'b1, value14: V14_MAX, last: 1'b1};
    add_row(16'd0,     16'd0,     1'b0, 32'd0, 0, '0, '0);
    add_row(16'hFFFF,  16'hFFFF,  1'b0, 32'd1, 0, '0, '0);
    add_row(16'hFFFF,  16'hFFFF,  1'b0, 32'd2, 2, x_top, y_top);
    add_row(16'hFFFF,  16'hFFFF,  1'b0, 32'd3, 0, '0, '0);
    for (int i = 4; i < 14; i++) add_row(16'd6000, 16'd0, 1'b0, 32'(i), -1, '0, '0);
    for (int i = 14; i < 18; i++) add_row(16'd0, 16'hFFFF, 1'b1, 32'(i), -1, '0, '0);
    add_row(16'd0,     16'd0,     1'b0, 32'hFFFF_FFFE, -1, '0, '0);
    add_row(16'd0,     16'd0,     1'b0, 32'hFFFF_FFFF, -1, '0, '0);
    add_row(16'd0,     16'd0,     1'b0, 32'd0,         -1, '0, '0);
    add_row(16'd0,     16'd0,     1'b1, 32'd1,         -1, '0, '0);
    add_row(16'd6000,  16'd6050,  1'b0, 32'd2,         -1, '0, '0);
    add_row(16'd6000,  16'd6050,  1'b0, 32'd3,         -1, '0, '0);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tk, dir_rows[i].n_typed,
                                    dir_rows[i].beat0, dir_rows[i].beat1);
    settle();

    // Ordered calibration, no rate limit, mirrored link, no deadzone.
    c.x_min         = 16'($urandom_range(0, 20000));
    c.x_center      = 16'($urandom_range(25000, 40000));
    c.x_max         = 16'($urandom_range(45000, 65535));
    c.y_min         = 16'($urandom_range(0, 20000));
    c.y_max         = 16'($urandom_range(45000, 65535));
    c.rate_limit_ms = 8'd0;
    c.link_style    = 1'b1;
    c.deadzone      = 14'd0;
    apply_cal(c);
    tick_ms = 32'hFFFF_FF00;
    run_random(260);
    settle();

    // Full-span X, Y range out of order, slowest rate limit; receiver busy less.
    in_idle_pct     = 56;
    out_idle_pct    = 15;
    c.x_min         = 16'd0;
    c.x_center      = 16'd32768;
    c.x_max         = 16'd65535;
    c.y_min         = 16'd40000;
    c.y_max         = 16'd30000;
    c.rate_limit_ms = 8'd255;
    c.link_style    = 1'b0;
    c.deadzone      = 14'($urandom_range(1, 300));
    apply_cal(c);
    run_random(260);
    settle();

    // X center below its minimum, widest deadzone, no idling at all.
    in_idle_pct     = 0;
    out_idle_pct    = 0;
    c.x_min         = 16'd50000;
    c.x_center      = 16'd20000;
    c.x_max         = 16'd60000;
    c.y_min         = 16'($urandom_range(0, 20000));
    c.y_max         = 16'($urandom_range(45000, 65535));
    c.rate_limit_ms = 8'($urandom_range(1, 20));
    c.link_style    = 1'b1;
    c.deadzone      = 14'd8192;
    apply_cal(c);
    run_random(260);
    settle();

    $display("Drove %0d ticks (directed table plus three random calibrations).", ticks_sent);
    $display("Checked %0d result beats and every register readback.", beats_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
